// ===== rtl/rckto_pkg.sv =====
// Package for the rotated color-key texture overlay.
// Field widths, register indexes, rotation codes, reset values and the
// issue word that passes from the raster unit to the merge unit. No dependencies.
package rckto_pkg;

  // field widths fixed by the pixel and register formats
  localparam int SIZE_W     = 7;
  localparam int ROT_W      = 2;
  localparam int PIX_W      = 8;
  localparam int TADDR_W    = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // default texture edge bound
  localparam int MAX_SIZE_DEF = 64;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUPER_TRANS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANS_COLOR = 2'd3;

  // input word operations
  localparam logic OP_LOAD_TOP = 1'b0;
  localparam logic OP_BOTTOM   = 1'b1;

  // rotation codes (quarter turns)
  localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
  localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
  localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
  localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

  // register reset values
  localparam logic [SIZE_W-1:0] SIZE_RST        = 7'd64;
  localparam logic [ROT_W-1:0]  ROTATION_RST    = ROT_0;
  localparam logic              SUPER_RST       = 1'b0;
  localparam logic [PIX_W-1:0]  TRANS_COLOR_RST = 8'd255;

  // top color remapped to the transparent color in super-transparent mode
  localparam logic [PIX_W-1:0] SUPER_KEY = 8'd254;

  // bottom pixel waiting for its top pixel to come out of the store
  typedef struct packed {
    logic             valid;
    logic [PIX_W-1:0] bottom;
    logic             last;
  } issue_t;

endpackage

// ===== rtl/rckto_pix_if.sv =====
// Input channel: top texture loads and bottom pixel words.
// Depends on rckto_pkg.
interface rckto_pix_if;
  import rckto_pkg::*;

  logic               valid;
  logic               ready;
  logic               op;
  logic [TADDR_W-1:0] top_address;
  logic [PIX_W-1:0]   pixel;

  modport source (output valid, op, top_address, pixel, input ready);
  modport sink   (input valid, op, top_address, pixel, output ready);
endinterface

// ===== rtl/rckto_out_if.sv =====
// Output channel: composited pixel words with end-of-texture flag.
// Depends on rckto_pkg.
interface rckto_out_if;
  import rckto_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] merged_pixel;
  logic             last;

  modport source (output valid, merged_pixel, last, input ready);
  modport sink   (input valid, merged_pixel, last, output ready);
endinterface

// ===== rtl/rckto_cfg_if.sv =====
// Configuration write channel: register index and write data.
// Depends on rckto_pkg.
interface rckto_cfg_if;
  import rckto_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/rckto_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module rckto_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/rckto_raster.sv =====
// Raster position tracking and rotated store addressing.
// Turns each bottom pixel into a store read, each top load inside the store into a store write.
// Depends on rckto_pkg.
module rckto_raster #(
  parameter int MAX_SIZE = rckto_pkg::MAX_SIZE_DEF,
  localparam int DEPTH  = MAX_SIZE * MAX_SIZE,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic                         op,
  input  logic [rckto_pkg::TADDR_W-1:0] top_address,
  input  logic [rckto_pkg::PIX_W-1:0]  pixel,
  input  logic [rckto_pkg::SIZE_W-1:0] size,
  input  logic [rckto_pkg::ROT_W-1:0]  rotation,
  output logic                         we,
  output logic [ADDR_W-1:0]            waddr,
  output logic                         re,
  output logic [ADDR_W-1:0]            raddr,
  output rckto_pkg::issue_t            issue
);
  import rckto_pkg::*;

  localparam int POS_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int SW    = $clog2(MAX_SIZE + 1);
  localparam int CW    = (SIZE_W > SW) ? SIZE_W : SW;
  localparam int PW    = SW + POS_W + 1;

  logic [POS_W-1:0] row, col;
  logic [POS_W-1:0] row_next, col_next;
  logic [CW-1:0]    size_c;
  logic [SW-1:0]    edge_len;
  logic [SW-1:0]    edge_m1;
  logic             pos_out;
  logic [POS_W-1:0] r_eff, c_eff, r_inv, c_inv;
  logic [POS_W-1:0] mul_a, add_b;
  logic [PW-1:0]    prod;
  logic             last_c;
  logic [SW-1:0]    col_inc, row_inc;

  // effective edge length: zero counts as one, saturate at MAX_SIZE
  always_comb begin
    size_c = CW'(size);
    if (size_c == '0) begin
      edge_len = SW'(1);
    end else if (size_c > CW'(MAX_SIZE)) begin
      edge_len = SW'(MAX_SIZE);
    end else begin
      edge_len = SW'(size_c);
    end
    edge_m1 = edge_len - SW'(1);
  end

  // restart the raster if a smaller size left it outside the texture
  always_comb begin
    pos_out = (SW'(row) >= edge_len) || (SW'(col) >= edge_len);
    r_eff   = pos_out ? '0 : row;
    c_eff   = pos_out ? '0 : col;
    r_inv   = POS_W'(edge_m1 - SW'(r_eff));
    c_inv   = POS_W'(edge_m1 - SW'(c_eff));
  end

  // rotated address: edge * a + b
  always_comb begin
    case (rotation)
      ROT_0: begin
        mul_a = r_eff;
        add_b = c_eff;
      end
      ROT_90: begin
        mul_a = c_eff;
        add_b = r_inv;
      end
      ROT_180: begin
        mul_a = r_inv;
        add_b = c_inv;
      end
      ROT_270: begin
        mul_a = c_inv;
        add_b = r_eff;
      end
      default: begin
        mul_a = r_eff;
        add_b = c_eff;
      end
    endcase
    prod  = PW'(edge_len) * PW'(mul_a);
    raddr = ADDR_W'(prod + PW'(add_b));
  end

  // end-of-texture flag and raster advance
  always_comb begin
    last_c  = (SW'(r_eff) == edge_m1) && (SW'(c_eff) == edge_m1);
    col_inc = SW'(c_eff) + SW'(1);
    row_inc = SW'(r_eff) + SW'(1);
    if (col_inc >= edge_len) begin
      col_next = '0;
      row_next = (row_inc >= edge_len) ? '0 : POS_W'(row_inc);
    end else begin
      col_next = POS_W'(col_inc);
      row_next = r_eff;
    end
  end

  // store port controls; writes beyond the store are dropped
  assign we    = accept && (op == OP_LOAD_TOP) && (32'(top_address) < DEPTH);
  assign waddr = ADDR_W'(top_address);
  assign re    = accept && (op == OP_BOTTOM);

  // raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else if (accept) begin
      if (op == OP_LOAD_TOP) begin
        row <= '0;
        col <= '0;
      end else begin
        row <= row_next;
        col <= col_next;
      end
    end
  end

  // bottom pixel travels alongside the store read
  always_ff @(posedge clk) begin
    if (rst) begin
      issue.valid <= 1'b0;
    end else begin
      issue.valid <= re;
    end
    if (re) begin
      issue.bottom <= pixel;
      issue.last   <= last_c;
    end
  end

endmodule

// ===== rtl/rckto_merge.sv =====
// Color-key merge of store data with the bottom pixel, output register
// and one-word skid buffer. Depends on rckto_pkg and rckto_out_if.
module rckto_merge (
  input  logic                       clk,
  input  logic                       rst,
  input  rckto_pkg::issue_t          issue,
  input  logic [rckto_pkg::PIX_W-1:0] rdata,
  input  logic [rckto_pkg::PIX_W-1:0] key,
  input  logic                       super_en,
  output logic                       take,
  rckto_out_if.source                res
);
  import rckto_pkg::*;

  logic             out_valid;
  logic [PIX_W-1:0] out_pix;
  logic             out_last;
  logic             hold_valid;
  logic [PIX_W-1:0] hold_pix;
  logic             hold_last;
  logic [PIX_W-1:0] merged_c;
  logic             out_free;

  // color-key select
  always_comb begin
    if (rdata == key) begin
      merged_c = issue.bottom;
    end else if (super_en && (rdata == SUPER_KEY)) begin
      merged_c = key;
    end else begin
      merged_c = rdata;
    end
  end

  assign out_free = !out_valid || res.ready;

  // room for one more word by the time a read issued now returns
  assign take = !hold_valid && !(issue.valid && out_valid && !res.ready);

  // valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= hold_valid || issue.valid;
      hold_valid <= 1'b0;
    end else if (issue.valid) begin
      hold_valid <= 1'b1;
    end
  end

  // payload: skid word drains first
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (hold_valid) begin
        out_pix  <= hold_pix;
        out_last <= hold_last;
      end else if (issue.valid) begin
        out_pix  <= merged_c;
        out_last <= issue.last;
      end
    end else if (issue.valid) begin
      hold_pix  <= merged_c;
      hold_last <= issue.last;
    end
  end

  assign res.valid        = out_valid;
  assign res.merged_pixel = out_pix;
  assign res.last         = out_last;

  // skid word only exists behind a held output word
  a_hold_needs_out: assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> out_valid)
    else $error("skid word present with empty output register");

  // no read may return while the skid word is occupied
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    !(hold_valid && issue.valid))
    else $error("store read returned with skid buffer full");

  // stalled output with a returning read parks it in the skid buffer
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    (issue.valid && out_valid && !res.ready) |=> hold_valid)
    else $error("returning read lost on output stall");

endmodule

// ===== rtl/rotated_color_key_texture_overlay.sv =====
// Rotated color-key texture overlay, top level.
// Depends on rckto_pkg, rckto_pix_if, rckto_out_if, rckto_cfg_if,
// rckto_ram, rckto_raster and rckto_merge.
//
//   port    dir   word contents
//   pix     in    op, top_address, pixel   (op 0 loads top, op 1 bottom pixel)
//   merged  out   merged_pixel, last       (one word per bottom pixel)
//   cfg     in    index, data              (size, rotation, super, color)
//
// One word per clock is accepted while ready is high. A bottom pixel reads
// the top store through its registered read port; its merged result is
// registered at the output. Reset clears the raster position and registers;
// the store is not cleared and must be loaded before use. An output stall
// parks one word in a skid buffer; input ready drops as soon as a returning
// read meets a stalled output and stays low until the skid word drains.
module rotated_color_key_texture_overlay #(
  parameter int MAX_SIZE = rckto_pkg::MAX_SIZE_DEF
) (
  input  logic         clk,
  input  logic         rst,
  rckto_pix_if.sink    pix,
  rckto_out_if.source  merged,
  rckto_cfg_if.sink    cfg
);
  import rckto_pkg::*;

  localparam int DEPTH  = MAX_SIZE * MAX_SIZE;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [SIZE_W-1:0] size;
  logic [ROT_W-1:0]  rotation;
  logic              super_transparent;
  logic [PIX_W-1:0]  transparent_color;

  logic              accept;
  logic              take;
  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [PIX_W-1:0]  rdata;
  issue_t            issue;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size              <= SIZE_RST;
      rotation          <= ROTATION_RST;
      super_transparent <= SUPER_RST;
      transparent_color <= TRANS_COLOR_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_SIZE:        size              <= SIZE_W'(cfg.data);
        CFG_ROTATION:    rotation          <= ROT_W'(cfg.data);
        CFG_SUPER_TRANS: super_transparent <= cfg.data[0];
        CFG_TRANS_COLOR: transparent_color <= cfg.data;
        default: ;
      endcase
    end
  end

  // input handshake
  assign pix.ready = take;
  assign accept    = pix.valid && take;

  rckto_raster #(.MAX_SIZE(MAX_SIZE)) u_raster (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .op          (pix.op),
    .top_address (pix.top_address),
    .pixel       (pix.pixel),
    .size        (size),
    .rotation    (rotation),
    .we          (we),
    .waddr       (waddr),
    .re          (re),
    .raddr       (raddr),
    .issue       (issue)
  );

  rckto_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_top_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (pix.pixel),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  rckto_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .issue    (issue),
    .rdata    (rdata),
    .key      (transparent_color),
    .super_en (super_transparent),
    .take     (take),
    .res      (merged)
  );

endmodule
